### design/jsv_pkg.sv
`timescale 1ns / 1ps

package jsv_pkg;

  // Stack sizing.
  localparam int STACK_DEPTH = 32;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);

  // Request kinds.
  localparam logic [2:0] K_BYTE    = 3'd0;
  localparam logic [2:0] K_END     = 3'd1;
  localparam logic [2:0] K_KEY     = 3'd2;
  localparam logic [2:0] K_VALUE   = 3'd3;
  localparam logic [2:0] K_RESTART = 3'd4;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_NUMBERS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ESCAPES  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_UNQUOTED = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STRICT   = 2'd3;

  // Value types.
  localparam logic [3:0] VT_ARRAY   = 4'd0;
  localparam logic [3:0] VT_OBJECT  = 4'd1;
  localparam logic [3:0] VT_STRING  = 4'd2;
  localparam logic [3:0] VT_NUMBER  = 4'd3;
  localparam logic [3:0] VT_FALSE   = 4'd4;
  localparam logic [3:0] VT_TRUE    = 4'd5;
  localparam logic [3:0] VT_NULL    = 4'd6;
  localparam logic [3:0] VT_KEY     = 4'd7;
  localparam logic [3:0] VT_BAREKEY = 4'd8;

  // Event kinds.
  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_START = 2'd1;
  localparam logic [1:0] EV_END   = 2'd2;

  // Error codes.
  localparam logic [4:0] E_NONE       = 5'd0;
  localparam logic [4:0] E_VALUE_CHAR = 5'd1;
  localparam logic [4:0] E_STRICT     = 5'd2;
  localparam logic [4:0] E_KEYWORD    = 5'd3;
  localparam logic [4:0] E_NUMBER     = 5'd4;
  localparam logic [4:0] E_NUM_END    = 5'd5;
  localparam logic [4:0] E_STR_END    = 5'd6;
  localparam logic [4:0] E_STR_CTRL   = 5'd7;
  localparam logic [4:0] E_ESC_END    = 5'd8;
  localparam logic [4:0] E_ESCAPE     = 5'd9;
  localparam logic [4:0] E_UNICODE    = 5'd10;
  localparam logic [4:0] E_KEY_EXP    = 5'd11;
  localparam logic [4:0] E_COLON      = 5'd12;
  localparam logic [4:0] E_INTERNAL   = 5'd13;
  localparam logic [4:0] E_OBJ_SEP    = 5'd14;
  localparam logic [4:0] E_ARR_SEP    = 5'd15;
  localparam logic [4:0] E_TRAILING   = 5'd16;
  localparam logic [4:0] E_PREMATURE  = 5'd17;
  localparam logic [4:0] E_EXT_KEY    = 5'd18;
  localparam logic [4:0] E_EXT_VALUE  = 5'd19;
  localparam logic [4:0] E_OVERFLOW   = 5'd20;

  // Port payloads.
  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] byte_value;
  } jsv_in_t;

  typedef struct packed {
    logic       accepted;
    logic [4:0] error_code;
    logic [1:0] event_kind;
    logic [3:0] value_type;
    logic [5:0] nest_depth;
    logic       doc_done;
  } jsv_out_t;

  // Classified request passed from the front to the back.
  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] byte_value;
    logic       is_byte;
    logic       is_end;
    logic       ws;
    logic       digit;
    logic       hexd;
    logic       esc;
    logic       bare;
    logic       numch;
    logic       ctrl;
  } jsv_item_t;

  // Parser states.
  typedef enum logic [16:0] {
    ST_START    = 17'b1 << 0,
    ST_STRICT   = 17'b1 << 1,
    ST_KEYWORD  = 17'b1 << 2,
    ST_NUMBER   = 17'b1 << 3,
    ST_STRING   = 17'b1 << 4,
    ST_ESC      = 17'b1 << 5,
    ST_HEX      = 17'b1 << 6,
    ST_KEYSTART = 17'b1 << 7,
    ST_BAREKEY  = 17'b1 << 8,
    ST_OBJEMPTY = 17'b1 << 9,
    ST_ARREMPTY = 17'b1 << 10,
    ST_GOTVAL   = 17'b1 << 11,
    ST_KEYDONE  = 17'b1 << 12,
    ST_STACK    = 17'b1 << 13,
    ST_OBJWAIT  = 17'b1 << 14,
    ST_ARRWAIT  = 17'b1 << 15,
    ST_DONE     = 17'b1 << 16
  } parse_state_t;

  // Number grammar states.
  typedef enum logic [9:0] {
    N_START    = 10'b1 << 0,
    N_MINUS    = 10'b1 << 1,
    N_ZERO     = 10'b1 << 2,
    N_INT      = 10'b1 << 3,
    N_FRAC     = 10'b1 << 4,
    N_FRACMORE = 10'b1 << 5,
    N_EXP      = 10'b1 << 6,
    N_EXPSIGN  = 10'b1 << 7,
    N_EXPMORE  = 10'b1 << 8,
    N_DONE     = 10'b1 << 9
  } num_state_t;

  typedef struct packed {
    logic       ok;
    num_state_t ns;
  } num_res_t;

  function automatic logic is_dig(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  // One step of the number grammar; a zero character marks the end of the number.
  function automatic num_res_t num_next(input num_state_t ns, input logic [7:0] c);
    num_res_t r;
    logic     is_exp;
    r.ok   = 1'b0;
    r.ns   = ns;
    is_exp = (c != 8'd0) && ((c | 8'h20) == "e");
    unique case (ns)
      N_START, N_MINUS: begin
        if (ns == N_START && c == "-") begin
          r.ok = 1'b1; r.ns = N_MINUS;
        end else if (c == "0") begin
          r.ok = 1'b1; r.ns = N_ZERO;
        end else if (is_dig(c)) begin
          r.ok = 1'b1; r.ns = N_INT;
        end
      end
      N_INT, N_ZERO: begin
        if (ns == N_INT && is_dig(c)) begin
          r.ok = 1'b1;
        end else if (c == ".") begin
          r.ok = 1'b1; r.ns = N_FRAC;
        end else if (is_exp) begin
          r.ok = 1'b1; r.ns = N_EXP;
        end else if (c == 8'd0) begin
          r.ok = 1'b1; r.ns = N_DONE;
        end
      end
      N_FRAC: begin
        if (is_dig(c)) begin
          r.ok = 1'b1; r.ns = N_FRACMORE;
        end
      end
      N_FRACMORE: begin
        if (is_dig(c)) begin
          r.ok = 1'b1;
        end else if (is_exp) begin
          r.ok = 1'b1; r.ns = N_EXP;
        end else if (c == 8'd0) begin
          r.ok = 1'b1; r.ns = N_DONE;
        end
      end
      N_EXP: begin
        if (c == "+" || c == "-") begin
          r.ok = 1'b1; r.ns = N_EXPSIGN;
        end else if (is_dig(c)) begin
          r.ok = 1'b1; r.ns = N_EXPMORE;
        end
      end
      N_EXPSIGN: begin
        if (is_dig(c)) begin
          r.ok = 1'b1; r.ns = N_EXPMORE;
        end
      end
      N_EXPMORE: begin
        if (is_dig(c)) begin
          r.ok = 1'b1;
        end else if (c == 8'd0) begin
          r.ok = 1'b1; r.ns = N_DONE;
        end
      end
      default: r.ok = 1'b0;
    endcase
    return r;
  endfunction

  // Remaining letters of false, true and null after the first one.
  function automatic logic [7:0] kw_char(input logic [1:0] id, input logic [1:0] pos);
    logic [7:0] ch;
    unique case ({id, pos})
      4'b00_00: ch = "a";
      4'b00_01: ch = "l";
      4'b00_10: ch = "s";
      4'b00_11: ch = "e";
      4'b01_00: ch = "r";
      4'b01_01: ch = "u";
      4'b01_10: ch = "e";
      4'b10_00: ch = "u";
      4'b10_01: ch = "l";
      4'b10_10: ch = "l";
      default:  ch = 8'd0;
    endcase
    return ch;
  endfunction

  function automatic logic [2:0] kw_len(input logic [1:0] id);
    return (id == 2'd0) ? 3'd4 : 3'd3;
  endfunction

endpackage

### design/jsv_front.sv
`timescale 1ns / 1ps

module jsv_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  jsv_pkg::jsv_in_t   in_data,
  output logic               q_valid,
  input  logic               q_ready,
  output jsv_pkg::jsv_item_t q_item
);
  import jsv_pkg::*;

  jsv_item_t  cls;
  jsv_item_t  slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       do_wr;
  logic       do_rd;
  logic [7:0] c;

  // Character classes for the incoming request.
  always_comb begin
    c              = in_data.byte_value;
    cls.kind       = in_data.kind;
    cls.byte_value = c;
    cls.is_byte    = (in_data.kind == K_BYTE);
    cls.is_end     = (in_data.kind == K_END);
    cls.ws         = cls.is_byte && (c == " " || c == 8'h09 || c == 8'h0A || c == 8'h0D);
    cls.digit      = cls.is_byte && is_dig(c);
    cls.hexd       = cls.is_byte && (is_dig(c) || (c >= "a" && c <= "f") ||
                                     (c >= "A" && c <= "F"));
    cls.esc        = cls.is_byte && (c == "\"" || c == "\\" || c == "/" || c == "b" ||
                                     c == "f" || c == "n" || c == "r" || c == "t");
    cls.bare       = cls.is_byte && (is_dig(c) || c == "_" || (c >= "a" && c <= "z") ||
                                     (c >= "A" && c <= "Z"));
    cls.numch      = cls.is_byte && (is_dig(c) || c == "." || c == "+" || c == "-" ||
                                     c == "e" || c == "E");
    cls.ctrl       = cls.is_byte && (c < 8'h20);
  end

  // Two-entry queue toward the parser.
  assign in_ready = (fill != 2'd2);
  assign q_valid  = (fill != 2'd0);
  assign q_item   = slot[rd_ptr];
  assign do_wr    = in_valid && in_ready;
  assign do_rd    = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_wr) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_rd) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + {1'b0, do_wr} - {1'b0, do_rd};
    end
  end

endmodule

### design/jsv_back.sv
`timescale 1ns / 1ps

module jsv_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [jsv_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  logic                              cfg_data,
  input  logic                              q_valid,
  output logic                              q_ready,
  input  jsv_pkg::jsv_item_t                q_item,
  output logic                              out_valid,
  input  logic                              out_ready,
  output jsv_pkg::jsv_out_t                 out_data
);
  import jsv_pkg::*;

  // Configuration.
  logic cfg_num;
  logic cfg_esc;
  logic cfg_uq;
  logic cfg_strict;

  // Parser state.
  parse_state_t ps;
  parse_state_t ps_next;
  parse_state_t st;
  logic [4:0]   err;
  logic [4:0]   err_next;
  logic [1:0]   kid;
  logic [1:0]   kid_next;
  logic [1:0]   kpos;
  logic [1:0]   kpos_next;
  num_state_t   nst;
  num_state_t   nst_next;
  logic [2:0]   hex;
  logic [2:0]   hex_next;

  // Stack: the two top entries are held in registers, the third is
  // prefetched from the memory every cycle.
  logic [3:0]       stk_mem [STACK_DEPTH];
  logic [3:0]       t0;
  logic [3:0]       t1;
  logic [3:0]       t2;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  logic [CNT_W-1:0] cnt_a;
  logic [CNT_W-1:0] rd_cnt;
  logic [3:0]       top;

  logic             step;
  logic             run;
  logic             restart;
  logic             full;
  logic             push;
  logic             push_req;
  logic [3:0]       push_t;
  logic             pop;
  logic [1:0]       evk;
  logic [3:0]       evt;
  logic [1:0]       kw_id;
  logic [2:0]       kw_pos1;
  logic [7:0]       c;
  logic             isb;
  num_res_t         nres;

  assign step    = q_valid && (!out_valid || out_ready);
  assign q_ready = step;
  assign c       = q_item.byte_value;
  assign isb     = q_item.is_byte;
  assign full    = (cnt >= CNT_W'(STACK_DEPTH));

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_num    <= 1'b1;
      cfg_esc    <= 1'b1;
      cfg_uq     <= 1'b0;
      cfg_strict <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_NUMBERS:  cfg_num    <= cfg_data;
        CFG_ESCAPES:  cfg_esc    <= cfg_data;
        CFG_UNQUOTED: cfg_uq     <= cfg_data;
        CFG_STRICT:   cfg_strict <= cfg_data;
        default:      cfg_num    <= cfg_num;
      endcase
    end
  end

  // One parse step per request: deferred pops and container checks first,
  // then the character itself.
  always_comb begin
    ps_next   = ps;
    err_next  = err;
    kid_next  = kid;
    kpos_next = kpos;
    nst_next  = nst;
    hex_next  = hex;
    evk       = EV_NONE;
    evt       = VT_ARRAY;
    push      = 1'b0;
    push_req  = 1'b0;
    push_t    = VT_ARRAY;
    pop       = 1'b0;
    restart   = 1'b0;
    run       = 1'b1;
    st        = ps;
    cnt_a     = cnt;
    top       = t0;
    kw_id     = (kid > 2'd2) ? 2'd2 : kid;
    kw_pos1   = {1'b0, kpos} + 3'd1;
    nres      = num_next(nst, c);

    if (q_item.kind == K_RESTART) begin
      restart  = 1'b1;
      err_next = E_NONE;
      ps_next  = cfg_strict ? ST_STRICT : ST_START;
    end else if (err == E_NONE) begin
      if (q_item.kind == K_BYTE || q_item.kind == K_END) begin
        // Leave states that end on a character they do not consume.
        if (st == ST_NUMBER && !q_item.numch) begin
          nres = num_next(nst, 8'd0);
          if (cfg_num && nst != N_DONE) begin
            if (!nres.ok) begin
              err_next = E_NUM_END;
              run      = 1'b0;
            end else begin
              nst_next = nres.ns;
              st       = ST_GOTVAL;
            end
          end else begin
            st = ST_GOTVAL;
          end
        end else if (st == ST_BAREKEY && !q_item.bare) begin
          st = ST_GOTVAL;
        end else if (st == ST_OBJEMPTY && !q_item.ws && !(isb && c == "}")) begin
          st = ST_KEYSTART;
        end else if (st == ST_ARREMPTY && !q_item.ws && !(isb && c == "]")) begin
          st = ST_START;
        end

        // Close the finished value.
        if (run && st == ST_GOTVAL) begin
          if (cnt == '0) begin
            err_next = E_INTERNAL;
            run      = 1'b0;
          end else begin
            pop = 1'b1;
            evk = EV_END;
            evt = t0;
            st  = (t0 == VT_KEY || t0 == VT_BAREKEY) ? ST_KEYDONE : ST_STACK;
          end
        end

        // Look at the enclosing container.
        if (run && st == ST_STACK) begin
          cnt_a = pop ? cnt - CNT_W'(1) : cnt;
          top   = pop ? t1 : t0;
          if (cnt_a == '0) begin
            st = ST_DONE;
          end else if (top == VT_OBJECT) begin
            st = ST_OBJWAIT;
          end else if (top == VT_ARRAY) begin
            st = ST_ARRWAIT;
          end else begin
            err_next = E_INTERNAL;
            run      = 1'b0;
          end
        end

        ps_next = st;

        // Consume the character.
        if (run) begin
          unique case (st)
            ST_START: begin
              if (q_item.ws) begin
                ps_next = st;
              end else if (isb && c == "{") begin
                push_req = 1'b1; push_t = VT_OBJECT;
                if (!full) ps_next = ST_OBJEMPTY;
              end else if (isb && c == "[") begin
                push_req = 1'b1; push_t = VT_ARRAY;
                if (!full) ps_next = ST_ARREMPTY;
              end else if (isb && c == "\"") begin
                push_req = 1'b1; push_t = VT_STRING;
                if (!full) ps_next = ST_STRING;
              end else if (isb && (c == "f" || c == "t" || c == "n")) begin
                kid_next = (c == "f") ? 2'd0 : (c == "t") ? 2'd1 : 2'd2;
                push_req = 1'b1;
                push_t   = VT_FALSE + {2'b00, kid_next};
                if (!full) begin
                  kpos_next = 2'd0;
                  ps_next   = ST_KEYWORD;
                end
              end else if (isb && (c == "-" || q_item.digit)) begin
                push_req = 1'b1; push_t = VT_NUMBER;
                if (!full) begin
                  if (cfg_num) begin
                    nres     = num_next(N_START, c);
                    nst_next = nres.ns;
                    if (!nres.ok) begin
                      err_next = E_NUMBER;
                    end else begin
                      ps_next = ST_NUMBER;
                    end
                  end else begin
                    ps_next = ST_NUMBER;
                  end
                end
              end else begin
                err_next = E_VALUE_CHAR;
              end
            end
            ST_STRICT: begin
              if (q_item.ws) begin
                ps_next = st;
              end else if (isb && c == "{") begin
                push_req = 1'b1; push_t = VT_OBJECT;
                if (!full) ps_next = ST_OBJEMPTY;
              end else if (isb && c == "[") begin
                push_req = 1'b1; push_t = VT_ARRAY;
                if (!full) ps_next = ST_ARREMPTY;
              end else begin
                err_next = E_STRICT;
              end
            end
            ST_KEYWORD: begin
              if (isb && ({1'b0, kpos} < kw_len(kw_id)) && c == kw_char(kw_id, kpos)) begin
                if (kw_pos1 >= kw_len(kw_id)) begin
                  ps_next = ST_GOTVAL;
                end else begin
                  kpos_next = kw_pos1[1:0];
                end
              end else begin
                err_next = E_KEYWORD;
              end
            end
            ST_NUMBER: begin
              if (cfg_num) begin
                nst_next = nres.ns;
                if (!nres.ok) err_next = E_NUMBER;
              end
            end
            ST_STRING: begin
              if (isb && c == "\\") begin
                ps_next = ST_ESC;
              end else if (isb && c == "\"") begin
                ps_next = ST_GOTVAL;
              end else if (q_item.is_end) begin
                err_next = E_STR_END;
              end else if (q_item.ctrl) begin
                err_next = E_STR_CTRL;
              end
            end
            ST_ESC: begin
              if (q_item.is_end) begin
                err_next = E_ESC_END;
              end else if (cfg_esc && c == "u") begin
                hex_next = 3'd4;
                ps_next  = ST_HEX;
              end else if (cfg_esc && !q_item.esc) begin
                err_next = E_ESCAPE;
              end else begin
                ps_next = ST_STRING;
              end
            end
            ST_HEX: begin
              if (!q_item.hexd) begin
                err_next = E_UNICODE;
              end else begin
                hex_next = hex - 3'd1;
                if (hex_next == 3'd0) ps_next = ST_STRING;
              end
            end
            ST_KEYSTART: begin
              if (q_item.ws) begin
                ps_next = st;
              end else if (isb && c == "\"") begin
                push_req = 1'b1; push_t = VT_KEY;
                if (!full) ps_next = ST_STRING;
              end else if (cfg_uq && q_item.bare) begin
                push_req = 1'b1; push_t = VT_BAREKEY;
                if (!full) ps_next = ST_BAREKEY;
              end else begin
                err_next = E_KEY_EXP;
              end
            end
            ST_BAREKEY: ps_next = st;
            ST_OBJEMPTY: begin
              if (isb && c == "}") ps_next = ST_GOTVAL;
            end
            ST_ARREMPTY: begin
              if (isb && c == "]") ps_next = ST_GOTVAL;
            end
            ST_KEYDONE: begin
              if (q_item.ws) begin
                ps_next = st;
              end else if (isb && c == ":") begin
                ps_next = ST_START;
              end else begin
                err_next = E_COLON;
              end
            end
            ST_OBJWAIT: begin
              if (q_item.ws) begin
                ps_next = st;
              end else if (isb && c == ",") begin
                ps_next = ST_KEYSTART;
              end else if (isb && c == "}") begin
                ps_next = ST_GOTVAL;
              end else begin
                err_next = E_OBJ_SEP;
              end
            end
            ST_ARRWAIT: begin
              if (q_item.ws) begin
                ps_next = st;
              end else if (isb && c == ",") begin
                ps_next = ST_START;
              end else if (isb && c == "]") begin
                ps_next = ST_GOTVAL;
              end else begin
                err_next = E_ARR_SEP;
              end
            end
            ST_DONE: begin
              if (!q_item.ws && !q_item.is_end) err_next = E_TRAILING;
            end
            default: err_next = E_INTERNAL;
          endcase
        end

        // Push a new open value unless the stack is full.
        if (push_req) begin
          if (full) begin
            err_next = E_OVERFLOW;
          end else begin
            push = 1'b1;
            evk  = EV_START;
            evt  = push_t;
          end
        end

        if (q_item.kind == K_END && err_next == E_NONE && ps_next != ST_DONE) begin
          err_next = E_PREMATURE;
        end
      end else if (q_item.kind == K_KEY) begin
        if (ps == ST_KEYSTART || ps == ST_OBJEMPTY) begin
          ps_next = ST_KEYDONE;
        end else begin
          err_next = E_EXT_KEY;
        end
      end else if (q_item.kind == K_VALUE) begin
        if (ps == ST_START || ps == ST_ARREMPTY) begin
          ps_next = ST_STACK;
        end else begin
          err_next = E_EXT_VALUE;
        end
      end
    end

    // Depth after this request, and the prefetch address of the third entry.
    if (!step) begin
      cnt_next = cnt;
    end else if (restart) begin
      cnt_next = '0;
    end else if (push) begin
      cnt_next = cnt + CNT_W'(1);
    end else if (pop) begin
      cnt_next = cnt - CNT_W'(1);
    end else begin
      cnt_next = cnt;
    end
    rd_cnt = cnt_next - CNT_W'(3);
  end

  // Stack memory and top-of-stack registers.
  always_ff @(posedge clk) begin
    if (step && !restart && push) begin
      stk_mem[cnt[ADDR_W-1:0]] <= push_t;
    end
    t2 <= stk_mem[rd_cnt[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (step && !restart) begin
      if (push) begin
        t0 <= push_t;
        t1 <= t0;
      end else if (pop) begin
        t0 <= t1;
        t1 <= t2;
      end
    end
  end

  // Parser control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      ps   <= ST_START;
      err  <= E_NONE;
      kid  <= 2'd0;
      kpos <= 2'd0;
      nst  <= N_START;
      hex  <= 3'd0;
      cnt  <= '0;
    end else if (step) begin
      ps   <= ps_next;
      err  <= err_next;
      kid  <= kid_next;
      kpos <= kpos_next;
      nst  <= nst_next;
      hex  <= hex_next;
      cnt  <= cnt_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data.accepted   <= (err_next == E_NONE);
      out_data.error_code <= err_next;
      out_data.event_kind <= evk;
      out_data.value_type <= evt;
      out_data.nest_depth <= 6'(cnt_next);
      out_data.doc_done   <= (err_next == E_NONE) && (ps_next == ST_DONE);
    end
  end

`ifndef SYNTH
  // The stack never holds more entries than it has room for.
  a_depth: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(STACK_DEPTH))
    else $error("stack count exceeds depth");

  // A standing error survives everything but a restart.
  a_sticky: assert property (@(posedge clk) disable iff (rst)
    (step && err != E_NONE && q_item.kind != K_RESTART) |=> (err == $past(err)))
    else $error("error code changed without restart");

  // A value start event always grows the stack by one.
  a_push: assert property (@(posedge clk) disable iff (rst)
    (step && evk == EV_START) |=> (cnt == $past(cnt) + CNT_W'(1)))
    else $error("start event without push");

  // A completed document has no open values.
  a_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.doc_done) |-> (out_data.nest_depth == 6'd0))
    else $error("document done with open values");
`endif

endmodule

### design/json_stream_validator.sv
`timescale 1ns / 1ps

// A request is held in the request queue and its result in the output register
// before the result is offered. Throughput: one request per cycle unless the
// output stalls; each character is one parse step with at most one stack push
// or pop, and the stack top entries are held in registers.
// Reset (synchronous, active high) empties the request queue and the output
// register and sets the default configuration, parse state and an empty stack.
module json_stream_validator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [jsv_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic                          cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  jsv_pkg::jsv_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output jsv_pkg::jsv_out_t             out_data
);
  import jsv_pkg::*;

  logic      q_valid;
  logic      q_ready;
  jsv_item_t q_item;

  // Request intake, classification and queue.
  jsv_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item)
  );

  // Parser, stack and result register.
  jsv_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
